@@ design/bsq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsq_pkg - shared types and constants for the B-spline stencil node query
// Register map, state encodings, job and result words, and per-axis helpers.
// ----------------------------------------------------------------------------
package bsq_pkg;

  localparam int unsigned MAX_DIM     = 256;  // upper clamp on a size register
  localparam int unsigned DIV_STEPS   = 32;   // quotient bits, one per cycle
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [2:0] {
    REG_SIZE_X    = 3'd0,
    REG_SIZE_Y    = 3'd1,
    REG_SIZE_Z    = 3'd2,
    REG_ORIGIN_X  = 3'd3,
    REG_ORIGIN_Y  = 3'd4,
    REG_ORIGIN_Z  = 3'd5,
    REG_CELL_SIZE = 3'd6
  } bsq_reg_t;

  typedef enum logic [2:0] {
    FR_IDLE,
    FR_REL,
    FR_DIV,
    FR_BASE,
    FR_SPAN,
    FR_MUL,
    FR_PUSH
  } bsq_front_state_t;

  typedef enum logic {
    BK_IDLE,
    BK_RUN
  } bsq_back_state_t;

  typedef struct packed {
    logic [8:0]  size_x;
    logic [8:0]  size_y;
    logic [8:0]  size_z;
    logic [31:0] origin_x;
    logic [31:0] origin_y;
    logic [31:0] origin_z;
    logic [30:0] cell_size;
  } bsq_cfg_t;

  // In-range stretch of one axis: stencil offsets lo..hi, node index at lo
  typedef struct packed {
    logic [1:0] lo;
    logic [1:0] hi;
    logic [7:0] g_lo;
  } bsq_axis_t;

  typedef struct packed {
    bsq_axis_t axis;
    logic      empty;
  } bsq_span_t;

  typedef struct packed {
    bsq_axis_t   x;
    bsq_axis_t   y;
    bsq_axis_t   z;
    logic [23:0] lin0;
    logic [8:0]  stride_y;
    logic [16:0] stride_x;
  } bsq_job_t;

  typedef struct packed {
    logic [7:0]  grid_x;
    logic [7:0]  grid_y;
    logic [7:0]  grid_z;
    logic [23:0] linear_index;
    logic [5:0]  stencil_pos;
    logic        is_last;
  } bsq_result_t;

  function automatic logic [8:0] eff_size(input logic [8:0] s);
    eff_size = (s > 9'(MAX_DIM)) ? 9'(MAX_DIM) : s;
  endfunction

  // base is the stencil origin along one axis, saturated to -4..256
  function automatic bsq_span_t axis_span(input logic signed [9:0] base,
                                          input logic [8:0] s);
    logic signed [11:0] b;
    logic signed [11:0] lo_f;
    logic signed [11:0] hi_f;
    logic signed [11:0] g_f;
    bsq_span_t          r;
    b    = {{2{base[9]}}, base};
    lo_f = b[11] ? -b : 12'sd0;
    hi_f = $signed({3'b000, s}) - 12'sd1 - b;
    g_f  = b + lo_f;
    r.empty    = (lo_f > hi_f) || (lo_f > 12'sd3);
    r.axis.lo  = lo_f[1:0];
    r.axis.hi  = (hi_f > 12'sd3) ? 2'd3 : hi_f[1:0];
    r.axis.g_lo = g_f[7:0];
    axis_span = r;
  endfunction

endpackage

@@ design/bsq_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsq_div - restoring floor divider for one axis
// One quotient bit per step; gives floor(rel / divisor) - 1, saturated.
// ----------------------------------------------------------------------------
module bsq_div (
  input  logic               clk,
  input  logic               load,
  input  logic               step,
  input  logic signed [32:0] rel,
  input  logic [30:0]        divisor,
  output logic signed [9:0]  base
);

  logic        neg_r;
  logic [30:0] rem_r;
  logic [31:0] quo_r;

  logic [32:0] mag;
  logic [31:0] rem_sh;
  logic [31:0] rem_sub;
  logic        ge;
  logic        rem_nz;
  logic signed [34:0] q_ext;
  logic signed [34:0] b35;

  assign mag     = rel[32] ? (33'd0 - rel) : rel;
  assign rem_sh  = {rem_r, quo_r[31]};
  assign ge      = rem_sh >= {1'b0, divisor};
  assign rem_sub = rem_sh - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (load) begin
      neg_r <= rel[32];
      rem_r <= '0;
      quo_r <= mag[31:0];
    end else if (step) begin
      rem_r <= ge ? rem_sub[30:0] : rem_sh[30:0];
      quo_r <= {quo_r[30:0], ge};
    end
  end

  // negative side: -Q - (rem != 0) - 1 = ~Q - (rem != 0)
  always_comb begin
    rem_nz = |rem_r;
    q_ext  = $signed({3'b000, quo_r});
    b35    = neg_r ? (~q_ext - $signed({34'd0, rem_nz})) : (q_ext - 35'sd1);
    if (b35 < -35'sd4) begin
      base = -10'sd4;
    end else if (b35 > 35'sd256) begin
      base = 10'sd256;
    end else begin
      base = b35[9:0];
    end
  end

endmodule

@@ design/bsq_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsq_front - point intake and stencil classification
// Divides each axis offset by the cell size, finds the in-range stretch of
// the stencil per axis, forms the start address and queues the job.
// ----------------------------------------------------------------------------
module bsq_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [31:0]       point_x,
  input  logic [31:0]       point_y,
  input  logic [31:0]       point_z,
  input  bsq_pkg::bsq_cfg_t cfg,
  input  logic              q_full,
  output logic              q_push,
  output bsq_pkg::bsq_job_t q_data
);

  localparam int CNT_W = $clog2(bsq_pkg::DIV_STEPS);

  bsq_pkg::bsq_front_state_t state_r, state_nxt;

  logic [CNT_W-1:0]   cnt_r;
  logic signed [32:0] rel_x_r, rel_y_r, rel_z_r;
  logic signed [9:0]  base_x_r, base_y_r, base_z_r;
  logic signed [9:0]  base_x, base_y, base_z;
  bsq_pkg::bsq_span_t span_x_r, span_y_r, span_z_r;
  logic [16:0]        sysz_r;
  logic [23:0]        prod_x_r;
  logic [16:0]        prod_y_r;

  logic        accept;
  logic        div_load;
  logic        div_step;
  logic        all_in;
  logic [30:0] divisor;
  logic [8:0]  sy_eff, sz_eff;
  logic [17:0] sysz;
  logic [24:0] prod_x;

  assign accept  = start && !busy;
  assign divisor = (cfg.cell_size == 31'd0) ? 31'd1 : cfg.cell_size;
  assign sy_eff  = bsq_pkg::eff_size(cfg.size_y);
  assign sz_eff  = bsq_pkg::eff_size(cfg.size_z);
  assign sysz    = sy_eff * sz_eff;
  assign prod_x  = span_x_r.axis.g_lo * sysz_r;
  assign all_in  = !span_x_r.empty && !span_y_r.empty && !span_z_r.empty;

  bsq_div u_div_x (.clk(clk), .load(div_load), .step(div_step), .rel(rel_x_r),
                   .divisor(divisor), .base(base_x));
  bsq_div u_div_y (.clk(clk), .load(div_load), .step(div_step), .rel(rel_y_r),
                   .divisor(divisor), .base(base_y));
  bsq_div u_div_z (.clk(clk), .load(div_load), .step(div_step), .rel(rel_z_r),
                   .divisor(divisor), .base(base_z));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bsq_pkg::FR_IDLE: if (start) state_nxt = bsq_pkg::FR_REL;
      bsq_pkg::FR_REL:  state_nxt = bsq_pkg::FR_DIV;
      bsq_pkg::FR_DIV: begin
        if (cnt_r == CNT_W'(bsq_pkg::DIV_STEPS - 1)) state_nxt = bsq_pkg::FR_BASE;
      end
      bsq_pkg::FR_BASE: state_nxt = bsq_pkg::FR_SPAN;
      bsq_pkg::FR_SPAN: state_nxt = bsq_pkg::FR_MUL;
      bsq_pkg::FR_MUL:  state_nxt = bsq_pkg::FR_PUSH;
      bsq_pkg::FR_PUSH: begin
        // drop a point with no node in range
        if (!all_in || !q_full) state_nxt = bsq_pkg::FR_IDLE;
      end
      default: state_nxt = bsq_pkg::FR_IDLE;
    endcase
  end

  always_comb begin
    busy     = (state_r != bsq_pkg::FR_IDLE);
    div_load = (state_r == bsq_pkg::FR_REL);
    div_step = (state_r == bsq_pkg::FR_DIV);
    q_push   = (state_r == bsq_pkg::FR_PUSH) && all_in && !q_full;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bsq_pkg::FR_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == bsq_pkg::FR_DIV) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else begin
        cnt_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rel_x_r <= $signed({point_x[31], point_x}) - $signed({cfg.origin_x[31], cfg.origin_x});
      rel_y_r <= $signed({point_y[31], point_y}) - $signed({cfg.origin_y[31], cfg.origin_y});
      rel_z_r <= $signed({point_z[31], point_z}) - $signed({cfg.origin_z[31], cfg.origin_z});
    end
    if (state_r == bsq_pkg::FR_BASE) begin
      base_x_r <= base_x;
      base_y_r <= base_y;
      base_z_r <= base_z;
    end
    if (state_r == bsq_pkg::FR_SPAN) begin
      span_x_r <= bsq_pkg::axis_span(base_x_r, bsq_pkg::eff_size(cfg.size_x));
      span_y_r <= bsq_pkg::axis_span(base_y_r, sy_eff);
      span_z_r <= bsq_pkg::axis_span(base_z_r, sz_eff);
      sysz_r   <= sysz[16:0];
    end
    if (state_r == bsq_pkg::FR_MUL) begin
      prod_x_r <= prod_x[23:0];
      prod_y_r <= span_y_r.axis.g_lo * sz_eff;
    end
  end

  always_comb begin
    q_data.x        = span_x_r.axis;
    q_data.y        = span_y_r.axis;
    q_data.z        = span_z_r.axis;
    q_data.lin0     = prod_x_r + {7'd0, prod_y_r} + {16'd0, span_z_r.axis.g_lo};
    q_data.stride_y = sz_eff;
    q_data.stride_x = sysz_r;
  end

endmodule

@@ design/bsq_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsq_fifo - short job queue between front and back
// Lets the front classify the next point while the back is still walking.
// ----------------------------------------------------------------------------
module bsq_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  bsq_pkg::bsq_job_t push_data,
  output logic              full,
  input  logic              pop,
  output bsq_pkg::bsq_job_t pop_data,
  output logic              empty
);

  localparam int PTR_W = $clog2(bsq_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(bsq_pkg::QUEUE_DEPTH + 1);

  bsq_pkg::bsq_job_t mem_r [bsq_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]  cnt_r;

  logic do_push, do_pop;

  assign full     = (cnt_r == CNT_W'(bsq_pkg::QUEUE_DEPTH));
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      if (do_pop)  rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

endmodule

@@ design/bsq_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsq_back - stencil walker
// Walks the in-range box of one job, one node per cycle, third axis
// innermost, and keeps the flat address up to date by stride adds.
// ----------------------------------------------------------------------------
module bsq_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_empty,
  input  bsq_pkg::bsq_job_t    q_data,
  output logic                 q_pop,
  output logic                 res_valid,
  output bsq_pkg::bsq_result_t res
);

  bsq_pkg::bsq_back_state_t state_r, state_nxt;

  bsq_pkg::bsq_job_t    job_r;
  logic [1:0]           a_r, b_r, c_r;
  logic [7:0]           gx_r, gy_r, gz_r;
  logic [23:0]          lin_r, row_r, plane_r;
  logic                 res_valid_r;
  bsq_pkg::bsq_result_t res_r;

  logic        at_end;
  logic        take;
  logic        emit;
  logic [23:0] row_nxt, plane_nxt;

  assign at_end    = (a_r == job_r.x.hi) && (b_r == job_r.y.hi) && (c_r == job_r.z.hi);
  assign row_nxt   = row_r + {15'd0, job_r.stride_y};
  assign plane_nxt = plane_r + {7'd0, job_r.stride_x};

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bsq_pkg::BK_IDLE: if (!q_empty) state_nxt = bsq_pkg::BK_RUN;
      bsq_pkg::BK_RUN:  if (at_end && q_empty) state_nxt = bsq_pkg::BK_IDLE;
      default:          state_nxt = bsq_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    emit  = (state_r == bsq_pkg::BK_RUN);
    take  = ((state_r == bsq_pkg::BK_IDLE) || at_end) && !q_empty;
    q_pop = take;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bsq_pkg::BK_IDLE;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      res_valid_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res_r.grid_x       <= gx_r;
      res_r.grid_y       <= gy_r;
      res_r.grid_z       <= gz_r;
      res_r.linear_index <= lin_r;
      res_r.stencil_pos  <= {a_r, b_r, c_r};
      res_r.is_last      <= at_end;
    end
    if (take) begin
      job_r   <= q_data;
      a_r     <= q_data.x.lo;
      b_r     <= q_data.y.lo;
      c_r     <= q_data.z.lo;
      gx_r    <= q_data.x.g_lo;
      gy_r    <= q_data.y.g_lo;
      gz_r    <= q_data.z.g_lo;
      lin_r   <= q_data.lin0;
      row_r   <= q_data.lin0;
      plane_r <= q_data.lin0;
    end else if (emit && !at_end) begin
      priority if (c_r != job_r.z.hi) begin
        c_r   <= c_r + 2'd1;
        gz_r  <= gz_r + 8'd1;
        lin_r <= lin_r + 24'd1;
      end else if (b_r != job_r.y.hi) begin
        // next row: rewind third axis
        b_r   <= b_r + 2'd1;
        gy_r  <= gy_r + 8'd1;
        c_r   <= job_r.z.lo;
        gz_r  <= job_r.z.g_lo;
        row_r <= row_nxt;
        lin_r <= row_nxt;
      end else begin
        // next plane: rewind second and third axes
        a_r     <= a_r + 2'd1;
        gx_r    <= gx_r + 8'd1;
        b_r     <= job_r.y.lo;
        gy_r    <= job_r.y.g_lo;
        c_r     <= job_r.z.lo;
        gz_r    <= job_r.z.g_lo;
        plane_r <= plane_nxt;
        row_r   <= plane_nxt;
        lin_r   <= plane_nxt;
      end
    end
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

endmodule

@@ design/bspline_stencil_node_query.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bspline_stencil_node_query - 4x4x4 cubic B-spline stencil node query
// Maps a particle position to the grid nodes of its stencil that lie inside
// the grid and streams them out with flat address and stencil position.
// ----------------------------------------------------------------------------
//
//  channel  ports                              handshake
//  -------  ---------------------------------  -------------------------------
//  input    in_point_x/y/z                     start & !busy
//  result   out_grid_x/y/z, out_linear_index,  out_valid, one cycle per word
//           out_stencil_pos, out_is_last
//  config   cfg_index, cfg_data                cfg_valid & cfg_ready
//
//  The front takes no new point until the last has left it: busy is high
//  from the accepting edge through the REL, DIV, BASE, SPAN, MUL and PUSH
//  states, the DIV state running the restoring dividers (one quotient bit per
//  cycle, three axes side by side), and while the two-entry job queue is full.
//  The back walks one node per cycle, so a full stencil of 64 nodes sets the
//  interval between points; the first word's strobe follows the push into
//  the job queue, through the back's state and result registers.
//  Reset is synchronous and clears control state and the config registers to defaults.
//  Results are never held off; out_valid is a one-cycle strobe per word.
//
module bspline_stencil_node_query (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_point_x,
  input  logic [31:0] in_point_y,
  input  logic [31:0] in_point_z,
  output logic        out_valid,
  output logic [7:0]  out_grid_x,
  output logic [7:0]  out_grid_y,
  output logic [7:0]  out_grid_z,
  output logic [23:0] out_linear_index,
  output logic [5:0]  out_stencil_pos,
  output logic        out_is_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  bsq_pkg::bsq_cfg_t    cfg_r;
  bsq_pkg::bsq_job_t    push_data, pop_data;
  bsq_pkg::bsq_result_t res;

  logic q_push, q_pop, q_full, q_empty;
  logic cfg_wr;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.size_x    <= 9'd64;
      cfg_r.size_y    <= 9'd64;
      cfg_r.size_z    <= 9'd64;
      cfg_r.origin_x  <= '0;
      cfg_r.origin_y  <= '0;
      cfg_r.origin_z  <= '0;
      cfg_r.cell_size <= 31'd65536;
    end else if (cfg_wr) begin
      unique case (bsq_pkg::bsq_reg_t'(cfg_index))
        bsq_pkg::REG_SIZE_X:    cfg_r.size_x    <= cfg_data[8:0];
        bsq_pkg::REG_SIZE_Y:    cfg_r.size_y    <= cfg_data[8:0];
        bsq_pkg::REG_SIZE_Z:    cfg_r.size_z    <= cfg_data[8:0];
        bsq_pkg::REG_ORIGIN_X:  cfg_r.origin_x  <= cfg_data;
        bsq_pkg::REG_ORIGIN_Y:  cfg_r.origin_y  <= cfg_data;
        bsq_pkg::REG_ORIGIN_Z:  cfg_r.origin_z  <= cfg_data;
        bsq_pkg::REG_CELL_SIZE: cfg_r.cell_size <= cfg_data[30:0];
        default: ;  // drop writes beyond the map
      endcase
    end
  end

  bsq_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .point_x (in_point_x),
    .point_y (in_point_y),
    .point_z (in_point_z),
    .cfg     (cfg_r),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_data  (push_data)
  );

  bsq_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (pop_data),
    .empty     (q_empty)
  );

  bsq_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_data    (pop_data),
    .q_pop     (q_pop),
    .res_valid (out_valid),
    .res       (res)
  );

  assign out_grid_x       = res.grid_x;
  assign out_grid_y       = res.grid_y;
  assign out_grid_z       = res.grid_z;
  assign out_linear_index = res.linear_index;
  assign out_stencil_pos  = res.stencil_pos;
  assign out_is_last      = res.is_last;

  logic [8:0] sx_eff, sy_eff, sz_eff;
  assign sx_eff = bsq_pkg::eff_size(cfg_r.size_x);
  assign sy_eff = bsq_pkg::eff_size(cfg_r.size_y);
  assign sz_eff = bsq_pkg::eff_size(cfg_r.size_z);

  a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted point did not make the front busy");

  a_walk_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_last |=> out_valid && (out_stencil_pos > $past(out_stencil_pos)))
    else $error("stencil walk broke off or went backwards before its last node");

  a_node_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ({1'b0, out_grid_x} < sx_eff) && ({1'b0, out_grid_y} < sy_eff)
                  && ({1'b0, out_grid_z} < sz_eff))
    else $error("emitted node lies outside the grid");

  a_queue_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_full && !q_pop |=> q_full)
    else $error("job queue lost an entry");

endmodule

@@ dv/tb_bspline_stencil_node_query.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bspline_stencil_node_query - self-checking bench for the stencil query
// Drives particle positions under a range of grid settings, predicts or looks
// up the in-grid stencil nodes of each point and compares every node word the
// block streams out, field by field, in order. Sender gaps are random.
// ----------------------------------------------------------------------------
module tb_bspline_stencil_node_query;

  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned IDLE_GUARD  = 200;   // front plus job queue, with margin
  localparam int unsigned CORNER_PTS  = 12;
  localparam int unsigned RAND_PHASES = 6;
  localparam int unsigned RAND_PTS    = 20;

  typedef struct packed {
    logic [31:0]          px;
    logic [31:0]          py;
    logic [31:0]          pz;
    logic                 typed;     // expectation written out below
    logic                 one_word;  // typed rows: one node word, else none
    bsq_pkg::bsq_result_t word;
  } point_row_t;

  localparam bsq_pkg::bsq_result_t NO_WORD = '0;

  localparam point_row_t POINT_ROWS [14] = '{
    // two cells below the grid: only the far corner node survives
    '{32'hFFFE0000, 32'hFFFE0000, 32'hFFFE0000, 1'b1, 1'b1,
      '{8'd0, 8'd0, 8'd0, 24'd0, 6'd63, 1'b1}},
    '{32'hFFFE0001, 32'hFFFE0001, 32'hFFFE0001, 1'b1, 1'b1,
      '{8'd0, 8'd0, 8'd0, 24'd0, 6'd63, 1'b1}},
    // one lsb further down floors a cell lower: nothing in range
    '{32'hFFFDFFFF, 32'hFFFDFFFF, 32'hFFFDFFFF, 1'b1, 1'b0, NO_WORD},
    // on the upper face: only the near corner node
    '{32'h00400000, 32'h00400000, 32'h00400000, 1'b1, 1'b1,
      '{8'd63, 8'd63, 8'd63, 24'h03FFFF, 6'd0, 1'b1}},
    '{32'h80000000, 32'h80000000, 32'h80000000, 1'b1, 1'b0, NO_WORD},
    '{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 1'b1, 1'b0, NO_WORD},
    '{32'h80000000, 32'h7FFFFFFF, 32'h00000000, 1'b1, 1'b0, NO_WORD},
    '{32'h00000000, 32'h00000000, 32'h00000000, 1'b0, 1'b0, NO_WORD},
    '{32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0, 1'b0, NO_WORD},
    '{32'h00008000, 32'h00008000, 32'h00008000, 1'b0, 1'b0, NO_WORD},
    '{32'h55555555, 32'hAAAAAAAA, 32'h55555555, 1'b0, 1'b0, NO_WORD},
    '{32'h00200000, 32'h00018000, 32'h003FFFFF, 1'b0, 1'b0, NO_WORD},
    '{32'h001F8000, 32'h0000FFFF, 32'h00010000, 1'b0, 1'b0, NO_WORD},
    '{32'h003FFFFF, 32'h003FFFFF, 32'h003FFFFF, 1'b0, 1'b0, NO_WORD}
  };

  // grid settings at the corners of the register ranges
  localparam bsq_pkg::bsq_cfg_t CORNER_CFGS [6] = '{
    '{9'd256, 9'd256, 9'd256, 32'h80000000, 32'h80000000, 32'h80000000, 31'd1},
    '{9'd511, 9'd300, 9'd257, 32'h00000000, 32'h00000000, 32'h00000000, 31'd65536},
    '{9'd8,   9'd0,   9'd8,   32'h00000000, 32'h00000000, 32'h00000000, 31'd65536},
    '{9'd4,   9'd4,   9'd4,   32'h7FFFFFFF, 32'hFFFFFFF0, 32'h00000010, 31'd0},
    '{9'd2,   9'd2,   9'd2,   32'h80000000, 32'h80000000, 32'h80000000, 31'h7FFFFFFF},
    '{9'd1,   9'd1,   9'd1,   32'h00000000, 32'hFFFF8000, 32'h00008000, 31'd65536}
  };

  logic        clk = 1'b0;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [31:0] in_point_x;
  logic [31:0] in_point_y;
  logic [31:0] in_point_z;
  logic        out_valid;
  logic [7:0]  out_grid_x;
  logic [7:0]  out_grid_y;
  logic [7:0]  out_grid_z;
  logic [23:0] out_linear_index;
  logic [5:0]  out_stencil_pos;
  logic        out_is_last;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  bsq_pkg::bsq_cfg_t    grid_cfg;
  bsq_pkg::bsq_result_t pending_nodes [$];
  int                   errors = 0;
  int unsigned          cycles = 0;

  bspline_stencil_node_query dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_point_x       (in_point_x),
    .in_point_y       (in_point_y),
    .in_point_z       (in_point_z),
    .out_valid        (out_valid),
    .out_grid_x       (out_grid_x),
    .out_grid_y       (out_grid_y),
    .out_grid_z       (out_grid_z),
    .out_linear_index (out_linear_index),
    .out_stencil_pos  (out_stencil_pos),
    .out_is_last      (out_is_last),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic longint node_count(input logic [8:0] s);
    return (s > 9'(bsq_pkg::MAX_DIM)) ? longint'(bsq_pkg::MAX_DIM) : longint'(s);
  endfunction

  function automatic longint cell_step();
    return (grid_cfg.cell_size == '0) ? 64'sd1 : longint'(grid_cfg.cell_size);
  endfunction

  // first stencil node along one axis: floor((p - o) / step) - 1
  function automatic longint stencil_base(input logic [31:0] p, input logic [31:0] o);
    longint rel;
    longint step;
    longint q;
    step = cell_step();
    rel  = longint'($signed(p)) - longint'($signed(o));
    q    = rel / step;
    if ((rel % step) != 0 && rel < 0)
      q = q - 1;
    return q - 1;
  endfunction

  // queue the in-grid nodes of one point, stencil order, last one marked
  function automatic void predict_nodes(input logic [31:0] px, input logic [31:0] py,
                                        input logic [31:0] pz);
    longint               sx, sy, sz;
    longint               bx, by, bz;
    longint               gx, gy, gz;
    longint               lin;
    bsq_pkg::bsq_result_t words [$];
    bsq_pkg::bsq_result_t w;
    sx = node_count(grid_cfg.size_x);
    sy = node_count(grid_cfg.size_y);
    sz = node_count(grid_cfg.size_z);
    bx = stencil_base(px, grid_cfg.origin_x);
    by = stencil_base(py, grid_cfg.origin_y);
    bz = stencil_base(pz, grid_cfg.origin_z);
    for (int a = 0; a < 4; a++) begin
      gx = bx + a;
      if (gx < 0 || gx >= sx) continue;
      for (int b = 0; b < 4; b++) begin
        gy = by + b;
        if (gy < 0 || gy >= sy) continue;
        for (int c = 0; c < 4; c++) begin
          gz = bz + c;
          if (gz < 0 || gz >= sz) continue;
          lin = (gx * sy + gy) * sz + gz;
          w.grid_x       = 8'(gx);
          w.grid_y       = 8'(gy);
          w.grid_z       = 8'(gz);
          w.linear_index = 24'(lin);
          w.stencil_pos  = 6'(16 * a + 4 * b + c);
          w.is_last      = 1'b0;
          words.insert(words.size(), w);
        end
      end
    end
    if (words.size() != 0)
      words[words.size() - 1].is_last = 1'b1;
    foreach (words[i])
      pending_nodes.insert(pending_nodes.size(), words[i]);
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    bsq_pkg::bsq_result_t want;
    if (rst_n && out_valid) begin
      if (pending_nodes.size() == 0) begin
        $error("node word with none expected: x %0d y %0d z %0d",
               out_grid_x, out_grid_y, out_grid_z);
        errors++;
      end else begin
        want = pending_nodes.pop_front();
        check_field("grid_x", want.grid_x, out_grid_x);
        check_field("grid_y", want.grid_y, out_grid_y);
        check_field("grid_z", want.grid_z, out_grid_z);
        check_field("linear_index", want.linear_index, out_linear_index);
        check_field("stencil_pos", want.stencil_pos, out_stencil_pos);
        check_field("is_last", want.is_last, out_is_last);
      end
    end
  end

  // hold the point until accepted; predict from the settings in force
  task automatic send_point(input logic [31:0] px, input logic [31:0] py,
                            input logic [31:0] pz, input bit predicted);
    start      <= 1'b1;
    in_point_x <= px;
    in_point_y <= py;
    in_point_z <= pz;
    do @(posedge clk); while (busy);
    if (predicted)
      predict_nodes(px, py, pz);
  endtask

  task automatic sender_gap();
    int unsigned g;
    int unsigned r;
    r = $urandom_range(99, 0);
    if (r < 50)      g = 0;
    else if (r < 85) g = $urandom_range(4, 1);
    else             g = $urandom_range(80, 20);
    if (g != 0) begin
      start <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending_nodes.size() != 0) @(posedge clk);
  endtask

  // write every register; upper data bits carry noise the block must drop
  task automatic load_grid(input bsq_pkg::bsq_cfg_t c);
    bsq_pkg::bsq_reg_t r;
    logic [31:0]       d;
    r = bsq_pkg::REG_SIZE_X;
    repeat (r.num()) begin
      d = $urandom();
      case (r)
        bsq_pkg::REG_SIZE_X:    d = {d[31:9], c.size_x};
        bsq_pkg::REG_SIZE_Y:    d = {d[31:9], c.size_y};
        bsq_pkg::REG_SIZE_Z:    d = {d[31:9], c.size_z};
        bsq_pkg::REG_ORIGIN_X:  d = c.origin_x;
        bsq_pkg::REG_ORIGIN_Y:  d = c.origin_y;
        bsq_pkg::REG_ORIGIN_Z:  d = c.origin_z;
        bsq_pkg::REG_CELL_SIZE: d = {d[31], c.cell_size};
        default:                d = '0;
      endcase
      cfg_valid <= 1'b1;
      cfg_index <= r;
      cfg_data  <= d;
      do @(posedge clk); while (!cfg_ready);
      r = r.next();
    end
    cfg_valid <= 1'b0;
    grid_cfg = c;
  endtask

  function automatic logic [8:0] pick_size();
    int unsigned r;
    r = $urandom_range(19, 0);
    if (r == 0)     return 9'd0;
    else if (r < 3) return 9'($urandom_range(511, 257));
    else if (r < 6) return 9'($urandom_range(256, 13));
    else            return 9'($urandom_range(12, 1));
  endfunction

  function automatic logic [31:0] pick_origin();
    if ($urandom_range(9, 0) < 3)
      return $urandom();
    return 32'(int'($urandom_range(1 << 25, 0)) - (1 << 24));
  endfunction

  function automatic bsq_pkg::bsq_cfg_t pick_grid();
    bsq_pkg::bsq_cfg_t c;
    int unsigned       r;
    c.size_x   = pick_size();
    c.size_y   = pick_size();
    c.size_z   = pick_size();
    c.origin_x = pick_origin();
    c.origin_y = pick_origin();
    c.origin_z = pick_origin();
    r = $urandom_range(9, 0);
    if (r == 0)      c.cell_size = 31'($urandom());
    else if (r == 1) c.cell_size = '0;
    else             c.cell_size = 31'($urandom_range(1 << 20, 1));
    return c;
  endfunction

  // mostly land somewhere around the grid, now and then anywhere at all
  function automatic logic [31:0] pick_coord(input logic [8:0] s, input logic [31:0] o);
    longint step;
    longint n;
    longint v;
    if ($urandom_range(4, 0) == 0)
      return $urandom();
    step = cell_step();
    n    = longint'($urandom_range(32'(node_count(s)) + 5, 0)) - 3;
    v    = longint'($signed(o)) + n * step + longint'($urandom_range(32'(step - 1), 0));
    return 32'(v);
  endfunction

  task automatic run_points(input int unsigned count);
    repeat (count) begin
      send_point(pick_coord(grid_cfg.size_x, grid_cfg.origin_x),
                 pick_coord(grid_cfg.size_y, grid_cfg.origin_y),
                 pick_coord(grid_cfg.size_z, grid_cfg.origin_z), 1'b1);
      if ($urandom_range(24, 0) == 0)
        drain();
      else
        sender_gap();
    end
  endtask

  // drain, then let points with no nodes clear the front before a write
  task automatic settle();
    drain();
    repeat (IDLE_GUARD) @(posedge clk);
  endtask

  initial begin
    rst_n      = 1'b0;
    start      = 1'b0;
    in_point_x = '0;
    in_point_y = '0;
    in_point_z = '0;
    cfg_valid  = 1'b0;
    cfg_index  = bsq_pkg::REG_SIZE_X;
    cfg_data   = '0;
    grid_cfg   = '{9'd64, 9'd64, 9'd64, 32'd0, 32'd0, 32'd0, 31'd65536};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (POINT_ROWS[i]) begin
      send_point(POINT_ROWS[i].px, POINT_ROWS[i].py, POINT_ROWS[i].pz,
                 !POINT_ROWS[i].typed);
      if (POINT_ROWS[i].typed && POINT_ROWS[i].one_word)
        pending_nodes.insert(pending_nodes.size(), POINT_ROWS[i].word);
      sender_gap();
    end

    foreach (CORNER_CFGS[i]) begin
      settle();
      load_grid(CORNER_CFGS[i]);
      run_points(CORNER_PTS);
    end

    repeat (RAND_PHASES) begin
      settle();
      load_grid(pick_grid());
      run_points(RAND_PTS);
    end

    drain();
    repeat (IDLE_GUARD) @(posedge clk);
    if (errors == 0 && pending_nodes.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

@@ sim.f @@
design/bsq_pkg.sv
design/bsq_div.sv
design/bsq_front.sv
design/bsq_fifo.sv
design/bsq_back.sv
design/bspline_stencil_node_query.sv
dv/tb_bspline_stencil_node_query.sv
